// File: rtl/core/bracketed_int_pair_parser_macros.svh
// Assertion macros shared by the bracketed integer pair parser RTL.
`ifndef BRACKETED_INT_PAIR_PARSER_MACROS_SVH
`define BRACKETED_INT_PAIR_PARSER_MACROS_SVH

// Check on every clock edge outside reset.
`define BIPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every clock edge, reset cycles included.
`define BIPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/bipp_pkg.sv
// Types, character codes and token helpers for the bracketed integer pair parser.
package bipp_pkg;

  localparam int unsigned MAX_FRAME = 256;
  localparam int unsigned CNT_W     = $clog2(MAX_FRAME + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    TI_FIRST  = 2'd0,
    TI_SECOND = 2'd1,
    TI_IGNORE = 2'd2,
    TI_ENDED  = 2'd3
  } tok_idx_t;

  typedef struct packed {
    tok_idx_t    idx;
    phase_t      phase;
    logic        present;
    logic        neg;
    logic [31:0] mag;
    logic [31:0] first_held;
    logic [31:0] second_held;
    logic [1:0]  marks;
  } parse_state_t;

  // Drop the token in progress.
  function automatic parse_state_t clear_token(parse_state_t s);
    parse_state_t n;
    n         = s;
    n.phase   = PH_LEAD;
    n.present = 1'b0;
    n.neg     = 1'b0;
    n.mag     = '0;
    return n;
  endfunction

  // Saturate the token in progress; store it in its slot if present and open.
  function automatic parse_state_t finish_token(parse_state_t s);
    parse_state_t n;
    logic [31:0]  v;
    n = s;
    if (s.neg) begin
      v = (s.mag >= MAG_CAP) ? MAG_CAP : (32'd0 - s.mag);
    end else begin
      v = (s.mag > POS_MAX) ? POS_MAX : s.mag;
    end
    if (s.present && !s.idx[1]) begin
      if (s.idx == TI_FIRST) begin
        n.first_held = v;
        n.marks[0]   = 1'b1;
      end else begin
        n.second_held = v;
        n.marks[1]    = 1'b1;
      end
      n.idx = tok_idx_t'(s.idx + 2'd1);
    end
    return clear_token(n);
  endfunction

endpackage

// File: rtl/core/bipp_char_step.sv
// Next parse state for one content byte of an open frame.
module bipp_char_step (
  input  bipp_pkg::parse_state_t state_cur,
  input  logic [7:0]             ch,
  output bipp_pkg::parse_state_t state_next
);

  logic        is_digit;
  logic        is_space;
  logic [35:0] mag_wide;
  logic [31:0] mag_sat;

  assign is_digit = (ch >= bipp_pkg::CH_ZERO) && (ch <= bipp_pkg::CH_NINE);
  assign is_space = (ch == bipp_pkg::CH_SPACE) ||
                    ((ch >= bipp_pkg::CH_TAB) && (ch <= bipp_pkg::CH_CR));

  // mag * 10 + digit as two shifts and two adds
  assign mag_wide = ({4'd0, state_cur.mag} << 3) + ({4'd0, state_cur.mag} << 1) +
                    {32'd0, ch[3:0]};
  assign mag_sat  = (mag_wide > {4'd0, bipp_pkg::MAG_CAP}) ? bipp_pkg::MAG_CAP
                                                           : mag_wide[31:0];

  always_comb begin
    state_next = state_cur;
    if (state_cur.idx[1]) begin
      state_next = state_cur;
    end else if (ch == bipp_pkg::CH_NUL) begin
      state_next     = bipp_pkg::finish_token(state_cur);
      state_next.idx = bipp_pkg::TI_ENDED;
    end else if (ch == bipp_pkg::CH_COMMA) begin
      state_next = bipp_pkg::finish_token(state_cur);
    end else begin
      state_next.present = 1'b1;
      case (state_cur.phase)
        bipp_pkg::PH_LEAD: begin
          if (is_space) begin
            state_next.phase = bipp_pkg::PH_LEAD;
          end else if ((ch == bipp_pkg::CH_PLUS) || (ch == bipp_pkg::CH_MINUS)) begin
            state_next.neg   = (ch == bipp_pkg::CH_MINUS);
            state_next.phase = bipp_pkg::PH_DIGITS;
          end else if (is_digit) begin
            state_next.phase = bipp_pkg::PH_DIGITS;
            state_next.mag   = mag_sat;
          end else begin
            state_next.phase = bipp_pkg::PH_DONE;
          end
        end
        bipp_pkg::PH_DIGITS: begin
          if (is_digit) begin
            state_next.mag = mag_sat;
          end else begin
            state_next.phase = bipp_pkg::PH_DONE;
          end
        end
        default: begin
          state_next.phase = state_cur.phase;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/bracketed_int_pair_parser.sv
// Top level of the bracketed integer pair parser: byte stage, parse state, result register.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------------------
//  rx       | rx_valid / rx_ready         | rx_byte
//  result   | result_valid / result_ready | first_number, second_number,
//           |                             | first_updated, second_updated
//
// One byte per cycle while no ']' waits. A byte is captured in the byte register, parsed
// from there against the parse state, and a ']' loads the result register, which drives
// result_valid. Reset clears the byte and result valid flags, the frame state and both
// held values. Only a ']' waits on the result side: it holds in the byte register
// while an earlier result beat is still untaken; every other byte advances regardless.
`include "bracketed_int_pair_parser_macros.svh"

module bracketed_int_pair_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_ready,
  input  logic [7:0]         rx_byte,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] first_number,
  output logic signed [31:0] second_number,
  output logic               first_updated,
  output logic               second_updated
);

  // byte register
  logic       pend_valid;
  logic [7:0] pend_byte;

  // frame and parse state
  logic                         in_frame;
  logic                         in_frame_next;
  logic [bipp_pkg::CNT_W-1:0]   stored_count;
  logic [bipp_pkg::CNT_W-1:0]   stored_count_next;
  bipp_pkg::parse_state_t       st;
  bipp_pkg::parse_state_t       st_next;
  bipp_pkg::parse_state_t       st_char;
  bipp_pkg::parse_state_t       st_close;

  logic is_close;
  logic is_open;
  logic out_free;
  logic advance;
  logic take_content;

  assign is_close = (pend_byte == bipp_pkg::CH_CLOSE);
  assign is_open  = (pend_byte == bipp_pkg::CH_OPEN);
  assign out_free = !result_valid || result_ready;
  // hold a ']' while the result register is still occupied
  assign advance  = pend_valid && (!is_close || out_free);
  assign rx_ready = !pend_valid || advance;

  assign take_content = in_frame && (stored_count < bipp_pkg::CNT_W'(bipp_pkg::MAX_FRAME));

  bipp_char_step u_step (
    .state_cur  (st),
    .ch         (pend_byte),
    .state_next (st_char)
  );

  always_comb begin
    // close the token in progress on ']' if the frame still wants one
    st_close = st;
    if (in_frame && !st.idx[1]) begin
      st_close = bipp_pkg::finish_token(st);
    end

    st_next           = st;
    in_frame_next     = in_frame;
    stored_count_next = stored_count;
    if (is_close) begin
      st_next           = bipp_pkg::clear_token(st_close);
      st_next.idx       = bipp_pkg::TI_FIRST;
      st_next.marks     = 2'b00;
      in_frame_next     = 1'b0;
      stored_count_next = '0;
    end else if (is_open) begin
      if (stored_count == '0) begin
        in_frame_next = 1'b1;
      end
    end else if (take_content) begin
      st_next           = st_char;
      stored_count_next = stored_count + bipp_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (rx_ready) begin
      pend_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ready && rx_valid) begin
      pend_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      stored_count <= '0;
      st           <= '0;
    end else if (advance) begin
      in_frame     <= in_frame_next;
      stored_count <= stored_count_next;
      st           <= st_next;
    end
  end

  // result register: load on an advancing ']', drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && is_close) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_close) begin
      first_number   <= st_close.first_held;
      second_number  <= st_close.second_held;
      first_updated  <= st_close.marks[0];
      second_updated <= st_close.marks[1];
    end
  end

  `BIPP_ASSERT(a_count_cap, stored_count <= bipp_pkg::CNT_W'(bipp_pkg::MAX_FRAME), "frame byte count past limit")
  `BIPP_ASSERT(a_idle_empty, !in_frame |-> (stored_count == '0), "content stored outside a frame")
  `BIPP_ASSERT(a_ignored_clear, st.idx[1] |-> (!st.present && (st.mag == '0)), "token live after parsing stopped")
  `BIPP_ASSERT_ALWAYS(a_reset_empty, rst |=> (!result_valid && !pend_valid), "pipeline not empty after reset")

endmodule
